/* rtl/ljf_pkg.sv */
`timescale 1ns / 1ps
package ljf_pkg;

    // fixed-point setup
    localparam int POS_FRAC_BITS = 16;
    localparam int ACC_WIDTH     = 64;
    localparam int CUT_SHIFT     = 2 * POS_FRAC_BITS - 16;
    localparam int RECIP_N       = 32 + 2 * POS_FRAC_BITS;
    localparam int RCNT_W        = $clog2(RECIP_N + 1);
    localparam int FRC_SHIFT     = POS_FRAC_BITS + 8;

    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SIX_Q32 = 64'h0000_0006_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] ACC_MAX = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] ACC_MIN = -ACC_MAX - 66'sd1;
    localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

    // register indexes
    localparam logic [2:0] CFG_SIGMA6 = 3'd0;
    localparam logic [2:0] CFG_EPS    = 3'd1;
    localparam logic [2:0] CFG_CUTSQ  = 3'd2;
    localparam logic [2:0] CFG_BX     = 3'd3;
    localparam logic [2:0] CFG_BY     = 3'd4;
    localparam logic [2:0] CFG_BZ     = 3'd5;
    localparam logic [2:0] CFG_PER    = 3'd6;

    // multiply steps, issued in this order
    localparam logic [4:0] OP_SQ0 = 5'd0;
    localparam logic [4:0] OP_SQ1 = 5'd1;
    localparam logic [4:0] OP_SQ2 = 5'd2;
    localparam logic [4:0] OP_UU  = 5'd3;
    localparam logic [4:0] OP_R6  = 5'd4;
    localparam logic [4:0] OP_A   = 5'd5;
    localparam logic [4:0] OP_EN  = 5'd6;
    localparam logic [4:0] OP_A12 = 5'd7;
    localparam logic [4:0] OP_FR0 = 5'd8;
    localparam logic [4:0] OP_FR1 = 5'd9;
    localparam logic [4:0] OP_FR2 = 5'd10;
    localparam logic [4:0] OP_FR3 = 5'd11;
    localparam logic [4:0] OP_FR4 = 5'd12;
    localparam logic [4:0] OP_FX  = 5'd13;
    localparam logic [4:0] OP_FY  = 5'd14;
    localparam logic [4:0] OP_FZ  = 5'd15;
    localparam logic [4:0] OP_OE0 = 5'd16;
    localparam logic [4:0] OP_OE1 = 5'd17;
    localparam logic [4:0] OP_OE2 = 5'd18;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic [4:0] op;
        logic       div_start;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic skip;
        logic last;
        logic out_busy;
    } t_stat;

    // clamp magnitude to int64 and apply sign
    function automatic logic [63:0] signed_of(input logic [63:0] mag, input logic neg);
        logic [63:0] v;
        v = mag[63] ? S64_MAX : mag;
        return neg ? 64'd0 - v : v;
    endfunction

    // saturating accumulate at ACC_WIDTH
    function automatic logic [ACC_WIDTH-1:0] acc_add(input logic [ACC_WIDTH-1:0] a,
                                                    input logic [63:0] b);
        logic signed [65:0] s;
        s = 66'(signed'(a)) + 66'(signed'(b));
        if (s > ACC_MAX) return ACC_MAX[ACC_WIDTH-1:0];
        if (s < ACC_MIN) return ACC_MIN[ACC_WIDTH-1:0];
        return s[ACC_WIDTH-1:0];
    endfunction

    // clamp to signed 48-bit output
    function automatic logic [47:0] out48(input logic [63:0] v);
        logic signed [63:0] s;
        s = signed'(v);
        if (s > OUT_MAX) return OUT_MAX[47:0];
        if (s < OUT_MIN) return OUT_MIN[47:0];
        return v[47:0];
    endfunction

endpackage

/* rtl/ljf_mul.sv */
`timescale 1ns / 1ps
module ljf_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [5:0]  i_sh,
    output logic        o_done,
    output logic [63:0] o_res
);
    // 64x64 saturating multiply, one 32x32 partial product per cycle
    logic [63:0]  r_a, r_b, r_res;
    logic [5:0]   r_sh;
    logic [127:0] r_p;
    logic [2:0]   r_cnt;
    logic         r_busy, r_done;

    logic [31:0]  a_h, b_h;
    logic [63:0]  pp;
    logic [1:0]   pos;
    logic [127:0] pp_sh, p_sh;

    always_comb begin
        a_h   = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        b_h   = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        pp    = a_h * b_h;
        pos   = 2'(r_cnt[1]) + 2'(r_cnt[0]);
        pp_sh = {64'd0, pp} << {pos, 5'd0};
        p_sh  = r_p >> r_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_p    <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_sh   <= i_sh;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= (|p_sh[127:64]) ? '1 : p_sh[63:0];
                end else begin
                    r_p   <= r_p + pp_sh;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

/* rtl/ljf_recip.sv */
`timescale 1ns / 1ps
module ljf_recip (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_q
);
    import ljf_pkg::*;

    // restoring divide of 2^RECIP_N by i_den, one quotient bit per cycle
    logic [63:0]       r_rem, r_q, r_den;
    logic              r_sat, r_busy, r_done;
    logic [RCNT_W-1:0] r_idx;

    logic        ge;
    logic [63:0] rs, nrem;

    always_comb begin
        rs   = {r_rem[62:0], r_idx == RCNT_W'(RECIP_N)};
        ge   = r_rem[63] || (rs >= r_den);
        nrem = ge ? rs - r_den : rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_q    <= '0;
                r_sat  <= 1'b0;
                r_idx  <= RCNT_W'(RECIP_N);
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= nrem;
                r_q   <= {r_q[62:0], ge};
                r_sat <= r_sat | r_q[63];
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx - RCNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_sat ? '1 : r_q;
endmodule

/* rtl/ljf_dp.sv */
`timescale 1ns / 1ps
module ljf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ljf_pkg::t_cmd      i_cmd,
    output ljf_pkg::t_stat     o_stat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_i_x,
    input  logic signed [31:0] i_i_y,
    input  logic signed [31:0] i_i_z,
    input  logic signed [31:0] i_j_x,
    input  logic signed [31:0] i_j_y,
    input  logic signed [31:0] i_j_z,
    input  logic signed [31:0] i_cell_dx,
    input  logic signed [31:0] i_cell_dy,
    input  logic signed [31:0] i_cell_dz,
    input  logic               i_last_pair,
    input  logic               i_ready,
    output logic               o_valid,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y,
    output logic signed [47:0] o_force_z,
    output logic signed [47:0] o_atom_energy
);
    import ljf_pkg::*;

    // configuration
    logic [31:0] r_s6, r_eps, r_cut;
    logic [30:0] r_bnd [3];
    logic        r_per;

    // pair state
    logic [31:0] r_mag [3];
    logic        r_neg [3];
    logic        r_far, r_last;
    logic [63:0] r_r2, r_t, r_r6, r_a, r_fr;
    logic [ACC_WIDTH-1:0] r_sum_f [3];
    logic [ACC_WIDTH-1:0] r_sum_e;

    // output register
    logic        r_out_valid;
    logic [47:0] r_out_f [3];
    logic [47:0] r_out_e;

    // reciprocal unit result
    logic [63:0] q_u;
    logic        d_done;

    // separation per axis from the input ports
    logic signed [31:0] pi [3], pj [3], pc [3];
    logic signed [33:0] c34 [3], c2 [3], bs [3], w [3];
    logic signed [34:0] d [3];
    logic [34:0]        dm [3];

    always_comb begin
        pi[0] = i_i_x;     pi[1] = i_i_y;     pi[2] = i_i_z;
        pj[0] = i_j_x;     pj[1] = i_j_y;     pj[2] = i_j_z;
        pc[0] = i_cell_dx; pc[1] = i_cell_dy; pc[2] = i_cell_dz;
        for (int k = 0; k < 3; k++) begin
            c34[k] = 34'(pc[k]);
            c2[k]  = c34[k] <<< 1;
            bs[k]  = signed'({3'b000, r_bnd[k]});
            if (r_per && (c2[k] < -bs[k]))
                w[k] = c34[k] + bs[k];
            else if (r_per && (c2[k] > bs[k]))
                w[k] = c34[k] - bs[k];
            else
                w[k] = c34[k];
            d[k]  = 35'(pi[k]) - 35'(pj[k]) + 35'(w[k]);
            dm[k] = d[k][34] ? 35'd0 - d[k] : d[k];
        end
    end

    // derived operands
    logic        eneg, cneg, sneg;
    logic [63:0] ediff, cmag, e64, eabs;
    logic [64:0] r2_sum;
    logic [95:0] cut_ext;

    always_comb begin
        eneg    = r_a < ONE_Q32;
        ediff   = eneg ? ONE_Q32 - r_a : r_a - ONE_Q32;
        cneg    = r_a < SIX_Q32;
        cmag    = cneg ? SIX_Q32 - r_a : r_a - SIX_Q32;
        e64     = 64'(signed'(r_sum_e));
        sneg    = e64[63];
        eabs    = sneg ? 64'd0 - e64 : e64;
        cut_ext = 96'(r_cut) << CUT_SHIFT;
    end

    // shared multiplier operand select
    logic [63:0] m_a, m_b, m_res;
    logic [5:0]  m_sh;
    logic        m_done;

    always_comb begin
        m_a  = r_fr;
        m_b  = r_fr;
        m_sh = 6'd32;
        case (i_cmd.op)
            OP_SQ0: begin m_a = 64'(r_mag[0]); m_b = 64'(r_mag[0]); m_sh = 6'd0; end
            OP_SQ1: begin m_a = 64'(r_mag[1]); m_b = 64'(r_mag[1]); m_sh = 6'd0; end
            OP_SQ2: begin m_a = 64'(r_mag[2]); m_b = 64'(r_mag[2]); m_sh = 6'd0; end
            OP_UU:  begin m_a = q_u;  m_b = q_u;  m_sh = 6'd32; end
            OP_R6:  begin m_a = r_t;  m_b = q_u;  m_sh = 6'd32; end
            OP_A:   begin m_a = 64'(r_s6); m_b = r_r6; m_sh = 6'd16; end
            OP_EN:  begin m_a = r_r6; m_b = ediff; m_sh = 6'd32; end
            OP_A12: begin m_a = r_a;  m_b = 64'd12; m_sh = 6'd0; end
            OP_FR0: begin m_a = q_u;  m_b = r_r6; m_sh = 6'd32; end
            OP_FR1: begin m_a = r_fr; m_b = cmag; m_sh = 6'd32; end
            OP_FR2: begin m_a = r_fr; m_b = 64'(r_s6); m_sh = 6'd16; end
            OP_FR3: begin m_a = r_fr; m_b = 64'(r_eps); m_sh = 6'd24; end
            OP_FR4: begin m_a = r_fr; m_b = 64'd4; m_sh = 6'd0; end
            OP_FX:  begin m_a = 64'(r_mag[0]); m_b = r_fr; m_sh = 6'(FRC_SHIFT); end
            OP_FY:  begin m_a = 64'(r_mag[1]); m_b = r_fr; m_sh = 6'(FRC_SHIFT); end
            OP_FZ:  begin m_a = 64'(r_mag[2]); m_b = r_fr; m_sh = 6'(FRC_SHIFT); end
            OP_OE0: begin m_a = eabs; m_b = 64'(r_eps); m_sh = 6'd24; end
            OP_OE1: begin m_a = r_t;  m_b = 64'(r_s6); m_sh = 6'd16; end
            OP_OE2: begin m_a = r_t;  m_b = 64'd1; m_sh = 6'd7; end
            default: begin m_a = r_fr; m_b = r_fr; m_sh = 6'd32; end
        endcase
        r2_sum = 65'(r_r2) + 65'(m_res);
    end

    ljf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .i_sh    (m_sh),
        .o_done  (m_done),
        .o_res   (m_res)
    );

    ljf_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_den   (r_r2),
        .o_done  (d_done),
        .o_q     (q_u)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6     <= 32'd65536;
            r_eps    <= 32'd16777216;
            r_cut    <= 32'd1638400;
            r_bnd[0] <= '0;
            r_bnd[1] <= '0;
            r_bnd[2] <= '0;
            r_per    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SIGMA6: r_s6     <= i_cfg_data;
                CFG_EPS:    r_eps    <= i_cfg_data;
                CFG_CUTSQ:  r_cut    <= i_cfg_data;
                CFG_BX:     r_bnd[0] <= i_cfg_data[30:0];
                CFG_BY:     r_bnd[1] <= i_cfg_data[30:0];
                CFG_BZ:     r_bnd[2] <= i_cfg_data[30:0];
                CFG_PER:    r_per    <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // pair load and multiply writeback
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= dm[k][31:0];
                r_neg[k] <= d[k][34];
            end
            r_far  <= (|dm[0][34:32]) | (|dm[1][34:32]) | (|dm[2][34:32]);
            r_last <= i_last_pair;
        end
        if (m_done) begin
            case (i_cmd.op)
                OP_SQ0: r_r2 <= m_res;
                OP_SQ1, OP_SQ2: r_r2 <= r2_sum[64] ? '1 : r2_sum[63:0];
                OP_UU, OP_OE0, OP_OE1, OP_OE2: r_t <= m_res;
                OP_R6:  r_r6 <= m_res;
                OP_A, OP_A12: r_a <= m_res;
                OP_FR0, OP_FR1, OP_FR2, OP_FR3, OP_FR4: r_fr <= m_res;
                default: ;
            endcase
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_f[0] <= '0;
            r_sum_f[1] <= '0;
            r_sum_f[2] <= '0;
            r_sum_e    <= '0;
        end else if (i_cmd.out_load) begin
            r_sum_f[0] <= '0;
            r_sum_f[1] <= '0;
            r_sum_f[2] <= '0;
            r_sum_e    <= '0;
        end else if (m_done) begin
            case (i_cmd.op)
                OP_EN: r_sum_e <= acc_add(r_sum_e, signed_of(m_res, eneg));
                OP_FX: r_sum_f[0] <= acc_add(r_sum_f[0], signed_of(m_res, r_neg[0] ^ cneg));
                OP_FY: r_sum_f[1] <= acc_add(r_sum_f[1], signed_of(m_res, r_neg[1] ^ cneg));
                OP_FZ: r_sum_f[2] <= acc_add(r_sum_f[2], signed_of(m_res, r_neg[2] ^ cneg));
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            for (int k = 0; k < 3; k++)
                r_out_f[k] <= out48(64'(signed'(r_sum_f[k])));
            r_out_e <= out48(signed_of(r_t, sneg));
        end
    end

    assign o_stat.mul_done = m_done;
    assign o_stat.div_done = d_done;
    assign o_stat.skip     = r_far || (r_r2 == '0) || ({32'd0, r_r2} > cut_ext);
    assign o_stat.last     = r_last;
    assign o_stat.out_busy = r_out_valid && !i_ready;

    assign o_valid       = r_out_valid;
    assign o_force_x     = r_out_f[0];
    assign o_force_y     = r_out_f[1];
    assign o_force_z     = r_out_f[2];
    assign o_atom_energy = r_out_e;
endmodule

/* rtl/ljf_ctrl.sv */
`timescale 1ns / 1ps
module ljf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ljf_pkg::t_stat i_stat,
    output ljf_pkg::t_cmd  o_cmd
);
    import ljf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [4:0] r_op, n_op;
    logic       r_kick, n_kick;

    // step sequencer
    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_kick          = 1'b0;
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_cmd.mul_start = r_kick;
        o_ready         = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_SQ0;
                    n_kick     = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (i_stat.mul_done) begin
                    if (r_op == OP_SQ2) begin
                        n_state = S_CHK;
                    end else if (r_op == OP_FZ) begin
                        n_state = S_FIN;
                    end else if (r_op == OP_OE2) begin
                        n_state = S_OUT;
                    end else begin
                        n_op   = r_op + 5'd1;
                        n_kick = 1'b1;
                    end
                end
            end
            S_CHK: begin
                if (i_stat.skip) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_op    = OP_UU;
                    n_kick  = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (i_stat.last) begin
                    n_op    = OP_OE0;
                    n_kick  = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_SQ0;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_kick  <= n_kick;
        end
    end
endmodule

/* rtl/lennard_jones_pair_force_accumulator.sv */
`timescale 1ns / 1ps
// Lennard-Jones 12-6 pair force accumulator. One pair transaction at a time:
// the time from acceptance until the input is ready again is set by the single
// shared 32x32 multiplier and the bit-serial reciprocal divider
// (2*POS_FRAC_BITS+33 quotient bits), plus any wait for a result still held
// in the output register. Each 64-bit product goes through start, four
// partial products, saturate and handoff; a pair inside the cutoff takes 16
// products, a pair outside it or at zero distance takes 3, and a last pair
// adds the energy scaling products. The result register lets a new pair
// start while the last result waits. Registers must be written by the user
// only while the block is idle; the block itself does not enforce it.
module lennard_jones_pair_force_accumulator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_i_x,
    input  logic signed [31:0] i_i_y,
    input  logic signed [31:0] i_i_z,
    input  logic signed [31:0] i_j_x,
    input  logic signed [31:0] i_j_y,
    input  logic signed [31:0] i_j_z,
    input  logic signed [31:0] i_cell_dx,
    input  logic signed [31:0] i_cell_dy,
    input  logic signed [31:0] i_cell_dz,
    input  logic               i_last_pair,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y,
    output logic signed [47:0] o_force_z,
    output logic signed [47:0] o_atom_energy
);
    import ljf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ljf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ljf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_i_x         (i_i_x),
        .i_i_y         (i_i_y),
        .i_i_z         (i_i_z),
        .i_j_x         (i_j_x),
        .i_j_y         (i_j_y),
        .i_j_z         (i_j_z),
        .i_cell_dx     (i_cell_dx),
        .i_cell_dy     (i_cell_dy),
        .i_cell_dz     (i_cell_dz),
        .i_last_pair   (i_last_pair),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_force_x     (o_force_x),
        .o_force_y     (o_force_y),
        .o_force_z     (o_force_z),
        .o_atom_energy (o_atom_energy)
    );
endmodule

/* rtl/ljf_chk.sv */
`timescale 1ns / 1ps
module ljf_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready
);
    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transfer");

    // one pair at a time: ready drops after each accepted transaction
    a_one_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second pair accepted while busy");

    // no result can appear right after a pair enters
    a_no_fast_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result appeared too early");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind lennard_jones_pair_force_accumulator ljf_chk u_ljf_chk (.*);

/* test/lennard_jones_pair_force_accumulator_test.sv */
`timescale 1ns / 1ps
module lennard_jones_pair_force_accumulator_test;
    import ljf_pkg::*;

    localparam logic [2:0]  CFG_NONE   = 3'd7;      // unmapped register index
    localparam int          LIMIT      = 6000000;
    localparam int          HOLD_LEN   = 3000;
    localparam int          DRAIN_WAIT = 400;
    localparam logic [63:0] U64_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [31:0] ix, iy, iz, jx, jy, jz, cx, cy, cz;
        logic               last;
    } pair_t;

    typedef struct {
        logic [47:0] fx, fy, fz, en;
    } force_t;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [31:0] i_i_x, i_i_y, i_i_z, i_j_x, i_j_y, i_j_z;
    logic signed [31:0] i_cell_dx, i_cell_dy, i_cell_dz;
    logic i_last_pair;
    logic signed [47:0] o_force_x, o_force_y, o_force_z, o_atom_energy;

    lennard_jones_pair_force_accumulator u_top (.*);

    // predictor copy of registers and sums
    logic [31:0] s6_r, eps_r, cut_r;
    logic [30:0] bx_r, by_r, bz_r;
    logic        per_r;
    logic [63:0] acc_fx, acc_fy, acc_fz, acc_en;

    pair_t  pend_q[$];
    force_t force_q[$];
    int     cyc, errors, n_pairs, n_results, n_inside;
    int     send_idle, recv_stall, hold_ask, hold_done, hold_cnt;
    logic   took;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // (a*b) >> sh with saturation at 64 bits
    function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p[127:64] != 0) ? U64_MAX : p[63:0];
    endfunction

    function automatic logic [63:0] clamp_signed(logic [63:0] mag, logic neg);
        logic [63:0] v;
        v = mag[63] ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
        return neg ? 64'd0 - v : v;
    endfunction

    function automatic logic [63:0] sat_accum(logic [63:0] a, logic [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic [47:0] clamp48(logic [63:0] v);
        longint s;
        s = $signed(v);
        if (s > 64'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic longint wrap_cell(longint c, logic [30:0] b);
        longint bb;
        bb = longint'(b);
        if (!per_r) return c;
        if (2 * c < -bb) return c + bb;
        if (2 * c > bb) return c - bb;
        return c;
    endfunction

    // add one pair into the running sums
    function automatic void accumulate_pair(longint d0, longint d1, longint d2);
        logic [63:0]  mag[3];
        logic [65:0]  r2w;
        logic [63:0]  r2, u, r6, a, a12, emag, cmag, fr;
        logic [127:0] q;
        logic         eneg, cneg;
        longint       d[3];
        d[0] = d0; d[1] = d1; d[2] = d2;
        r2w = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = d[i] < 0 ? 64'd0 - 64'(d[i]) : 64'(d[i]);
            if (mag[i] >= ONE_Q32) return;
            r2w += 66'(mag[i] * mag[i]);
        end
        r2 = (r2w[65:64] != 0) ? U64_MAX : r2w[63:0];
        if (r2 == 0) return;
        if ((r2 >> CUT_SHIFT) > {32'd0, cut_r}) return;
        if ((r2 >> CUT_SHIFT) == {32'd0, cut_r} && r2[CUT_SHIFT-1:0] != 0) return;
        n_inside++;

        q  = (128'd1 << RECIP_N) / {64'd0, r2};
        u  = (q[127:64] != 0) ? U64_MAX : q[63:0];
        r6 = sat_mul(sat_mul(u, u, 32), u, 32);
        a  = sat_mul({32'd0, s6_r}, r6, 16);

        eneg   = a < ONE_Q32;
        emag   = sat_mul(r6, eneg ? ONE_Q32 - a : a - ONE_Q32, 32);
        acc_en = sat_accum(acc_en, clamp_signed(emag, eneg));

        a12  = sat_mul(a, 64'd12, 0);
        cneg = a12 < SIX_Q32;
        cmag = cneg ? SIX_Q32 - a12 : a12 - SIX_Q32;
        fr   = sat_mul(u, r6, 32);
        fr   = sat_mul(fr, cmag, 32);
        fr   = sat_mul(fr, {32'd0, s6_r}, 16);
        fr   = sat_mul(fr, {32'd0, eps_r}, 24);
        fr   = sat_mul(fr, 64'd4, 0);

        acc_fx = sat_accum(acc_fx, clamp_signed(sat_mul(mag[0], fr, FRC_SHIFT), (d[0] < 0) != cneg));
        acc_fy = sat_accum(acc_fy, clamp_signed(sat_mul(mag[1], fr, FRC_SHIFT), (d[1] < 0) != cneg));
        acc_fz = sat_accum(acc_fz, clamp_signed(sat_mul(mag[2], fr, FRC_SHIFT), (d[2] < 0) != cneg));
    endfunction

    // apply one pair; a last pair queues the atom's force and energy
    function automatic void predict_force(pair_t p);
        longint      d0, d1, d2;
        logic [63:0] emag;
        logic        eneg;
        force_t      f;
        d0 = longint'(p.ix) - longint'(p.jx) + wrap_cell(longint'(p.cx), bx_r);
        d1 = longint'(p.iy) - longint'(p.jy) + wrap_cell(longint'(p.cy), by_r);
        d2 = longint'(p.iz) - longint'(p.jz) + wrap_cell(longint'(p.cz), bz_r);
        accumulate_pair(d0, d1, d2);
        if (!p.last) return;
        eneg = acc_en[63];
        emag = eneg ? 64'd0 - acc_en : acc_en;
        emag = sat_mul(emag, {32'd0, eps_r}, 24);
        emag = sat_mul(emag, {32'd0, s6_r}, 16);
        emag = sat_mul(emag, 64'd1, 7);
        f.fx = clamp48(acc_fx);
        f.fy = clamp48(acc_fy);
        f.fz = clamp48(acc_fz);
        f.en = clamp48(clamp_signed(emag, eneg));
        force_q.push_back(f);
        acc_fx = '0; acc_fy = '0; acc_fz = '0; acc_en = '0;
    endfunction

    // cycle count and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, force_q.size());
            $display("[lennard_jones_pair_force_accumulator] ERROR");
            $finish;
        end
    end

    // input monitor: predict on each accepted transaction
    always @(posedge i_clk) begin
        pair_t p;
        took <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            p.ix = i_i_x; p.iy = i_i_y; p.iz = i_i_z;
            p.jx = i_j_x; p.jy = i_j_y; p.jz = i_j_z;
            p.cx = i_cell_dx; p.cy = i_cell_dy; p.cz = i_cell_dz;
            p.last = i_last_pair;
            n_pairs++;
            predict_force(p);
        end
    end

    // output monitor: compare against the oldest expected result
    always @(posedge i_clk) begin
        force_t f;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (force_q.size() == 0) begin
                $display("%0t unexpected result fx=%h fy=%h fz=%h en=%h", $time,
                         o_force_x, o_force_y, o_force_z, o_atom_energy);
                errors++;
            end else begin
                f = force_q.pop_front();
                if (o_force_x !== f.fx) begin
                    $display("%0t force_x exp %h got %h", $time, f.fx, o_force_x);
                    errors++;
                end
                if (o_force_y !== f.fy) begin
                    $display("%0t force_y exp %h got %h", $time, f.fy, o_force_y);
                    errors++;
                end
                if (o_force_z !== f.fz) begin
                    $display("%0t force_z exp %h got %h", $time, f.fz, o_force_z);
                    errors++;
                end
                if (o_atom_energy !== f.en) begin
                    $display("%0t atom_energy exp %h got %h", $time, f.en, o_atom_energy);
                    errors++;
                end
            end
        end
    end

    // pair driver
    always @(negedge i_clk) begin
        pair_t p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || took) begin
            if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                p = pend_q.pop_front();
                i_i_x <= p.ix; i_i_y <= p.iy; i_i_z <= p.iz;
                i_j_x <= p.jx; i_j_y <= p.jy; i_j_z <= p.jz;
                i_cell_dx <= p.cx; i_cell_dy <= p.cy; i_cell_dz <= p.cz;
                i_last_pair <= p.last;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (hold_ask != hold_done) begin
            hold_done <= hold_done + 1;
            hold_cnt <= HOLD_LEN;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_SIGMA6: s6_r  = val;
            CFG_EPS:    eps_r = val;
            CFG_CUTSQ:  cut_r = val;
            CFG_BX:     bx_r  = val[30:0];
            CFG_BY:     by_r  = val[30:0];
            CFG_BZ:     bz_r  = val[30:0];
            CFG_PER:    per_r = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(logic [31:0] s6, logic [31:0] eps, logic [31:0] cut,
                             logic [30:0] bx, logic [30:0] by, logic [30:0] bz, logic per);
        write_reg(CFG_SIGMA6, s6);
        write_reg(CFG_EPS, eps);
        write_reg(CFG_CUTSQ, cut);
        write_reg(CFG_BX, {1'b0, bx});
        write_reg(CFG_BY, {1'b0, by});
        write_reg(CFG_BZ, {1'b0, bz});
        write_reg(CFG_PER, {31'd0, per});
    endtask

    function automatic pair_t mk_pair(int ix, int iy, int iz, int jx, int jy, int jz,
                                      int cx, int cy, int cz, logic last);
        pair_t p;
        p.ix = ix; p.iy = iy; p.iz = iz; p.jx = jx; p.jy = jy; p.jz = jz;
        p.cx = cx; p.cy = cy; p.cz = cz; p.last = last;
        return p;
    endfunction

    // cell offset that often exercises the minimum-image wrap
    function automatic int cell_offset(logic [30:0] b);
        int k;
        k = $urandom_range(9);
        if (k < 4) return 0;
        if (k < 6) return int'(b) - $urandom_range(65535);
        if (k < 8) return $urandom_range(65535) - int'(b);
        if (k < 9) return $signed($urandom_range(2 ** 18)) - 2 ** 17;
        return $urandom;
    endfunction

    // random pair: mostly close neighbors, some coincident atoms, some noise
    function automatic pair_t rand_pair(logic last);
        pair_t p;
        int    k;
        k = $urandom_range(99);
        if (k < 12) begin
            p = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, last);
        end else begin
            p.ix = $urandom_range(2 ** 19) - 2 ** 18;
            p.iy = $urandom_range(2 ** 19) - 2 ** 18;
            p.iz = $urandom_range(2 ** 19) - 2 ** 18;
            p.jx = p.ix + $urandom_range(2 ** 19) - 2 ** 18;
            p.jy = p.iy + $urandom_range(2 ** 19) - 2 ** 18;
            p.jz = p.iz + $urandom_range(2 ** 19) - 2 ** 18;
            if (k < 16) begin
                p.jx = p.ix; p.jy = p.iy; p.jz = p.iz;
                p.cx = 0; p.cy = 0; p.cz = 0;
            end else begin
                p.cx = cell_offset(bx_r);
                p.cy = cell_offset(by_r);
                p.cz = cell_offset(bz_r);
            end
            p.last = last;
        end
        return p;
    endfunction

    // queue n pairs in atom groups of 1..6 pairs, ending on a last pair
    task automatic queue_pairs(int n);
        int left;
        left = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
            left--;
            pend_q.push_back(rand_pair(left == 0 || i == n - 1));
            if (left == 0) left = $urandom_range(6, 1);
        end
    endtask

    // wait until the block is idle and every result has arrived
    task automatic drain();
        while (pend_q.size() != 0 || i_valid || force_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic rand_config(logic per);
        write_all($urandom_range(131072, 32768), $urandom_range(2 ** 26),
                  $urandom_range(6553600, 65536), 31'($urandom_range(2621440, 65536)),
                  31'($urandom_range(2621440, 65536)), 31'($urandom_range(2621440, 65536)),
                  per);
    endtask

    initial begin
        cyc = 0; errors = 0; n_pairs = 0; n_results = 0; n_inside = 0;
        send_idle = 0; recv_stall = 0; hold_ask = 0; hold_done = 0; hold_cnt = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0; i_cfg_we = 1'b0;
        i_cfg_addr = '0; i_cfg_data = '0; took = 1'b0;
        {i_i_x, i_i_y, i_i_z, i_j_x, i_j_y, i_j_z} = '0;
        {i_cell_dx, i_cell_dy, i_cell_dz} = '0;
        i_last_pair = 1'b0;
        s6_r = 32'd65536; eps_r = 32'd16777216; cut_r = 32'd1638400;
        bx_r = '0; by_r = '0; bz_r = '0; per_r = 1'b1;
        acc_fx = '0; acc_fy = '0; acc_fz = '0; acc_en = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pairs at reset settings
        pend_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));              // coincident
        pend_q.push_back(mk_pair(327680, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));         // on cutoff
        pend_q.push_back(mk_pair(327681, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));         // just outside
        pend_q.push_back(mk_pair(65536, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));          // at sigma
        pend_q.push_back(mk_pair(0, -70000, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        pend_q.push_back(mk_pair(0, 0, 1, 0, 0, 0, 0, 0, 0, 1'b1));              // tiny r
        pend_q.push_back(mk_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1)); // far
        pend_q.push_back(mk_pair(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0,
                                 32'h80000000, 0, 0, 1'b1));
        pend_q.push_back(mk_pair(-1, -1, -1, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 1'b1));
        pend_q.push_back(mk_pair(100000, 50000, -30000, 0, 0, 0, 0, 0, 0, 1'b0));
        pend_q.push_back(mk_pair(-90000, 40000, 20000, 0, 0, 0, 0, 0, 0, 1'b0));
        pend_q.push_back(mk_pair(200000, -200000, 100000, 0, 0, 0, 0, 0, 0, 1'b1));
        drain();

        // wrap cases with a 10.0 box, then the unmapped index
        write_all(32'd65536, 32'd16777216, 32'd1638400, 31'd655360, 31'd655360,
                  31'd655360, 1'b1);
        write_reg(CFG_NONE, 32'hFFFFFFFF);
        pend_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, 600000, 0, 0, 1'b1));        // wraps down
        pend_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, -600000, 0, 1'b1));       // wraps up
        pend_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 327680, 1'b1));        // half box
        pend_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, -327680, 0, 0, 1'b1));
        pend_q.push_back(mk_pair(0, 0, 0, 0, 0, 0, 327681, 0, 0, 1'b1));
        drain();

        // random settings, no idling
        rand_config(1'b1);
        queue_pairs(300);
        drain();

        // large extremes with the sender idling
        send_idle = 51;
        write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                  31'h7FFFFFFF, 1'b1);
        queue_pairs(220);
        drain();

        // zero extremes, then mixed extremes, with the receiver stalling and one long hold-off
        send_idle = 0;
        recv_stall = 51;
        write_all(32'd0, 32'd0, 32'd0, 31'd0, 31'd0, 31'd0, 1'b0);
        queue_pairs(30);
        drain();
        write_all(32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'd1310720, 31'd0, 31'd655360, 1'b0);
        hold_ask = hold_ask + 1;
        queue_pairs(200);
        drain();

        // both sides idling
        send_idle = 16;
        recv_stall = 16;
        rand_config(1'b1);
        queue_pairs(400);
        drain();

        // mixed settings, random idling per block of pairs
        for (int b = 0; b < 4; b++) begin
            send_idle = $urandom_range(60);
            recv_stall = $urandom_range(60);
            rand_config(1'($urandom_range(1)));
            queue_pairs(120);
            drain();
        end

        $display("%0d pair transactions (%0d inside cutoff), %0d atom results checked",
                 n_pairs, n_inside, n_results);
        $display("covered wrap, cutoff edge, coincident and far pairs, saturation, stalls");
        if (errors == 0) begin
            $display("[lennard_jones_pair_force_accumulator] OK");
        end else begin
            $display("[lennard_jones_pair_force_accumulator] ERROR");
        end
        $finish;
    end

endmodule
